// ----- hdl/mctp_pkg.sv -----
// shared types and constants for the multi-channel tick pwm block
// used by the controller, the datapath and the top level; depends on nothing

package mctp_pkg;

    localparam int CHAN_W    = 2;
    localparam int NUM_SLOTS = 1 << CHAN_W;
    localparam int FREQ_W    = 8;
    localparam int DUTY_W    = 8;
    localparam int PCT_W     = 7;
    localparam int FULL_DUTY = 100;
    localparam int LEVELS_W  = 4;
    localparam int IN_DATA_W = 24;
    localparam int IN_USER_W = 2;
    localparam int OUT_DATA_W = 8;

    // floor(x / 100) as (x * PCT_RECIP) >> RECIP_SHIFT, exact for x below 2^17
    localparam int                 RECIP_W     = 18;
    localparam int                 RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] PCT_RECIP   = 18'd167773;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV_P,
        ST_MUL,
        ST_SCALE,
        ST_APPLY,
        ST_STOP,
        ST_TICK,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic div_go;      // ticks per second / freq
        logic mul;
        logic scale;       // duty * period over 100
        logic write_start;
        logic write_stop;
        logic tick_step;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        action_t action;
        logic    bad_cmd;
        logic    div_done;
        logic    idx_last;
        logic    out_free;
    } sts_t;

endpackage

// ----- hdl/multi_channel_tick_pwm.sv -----
// top level of the four-channel pwm generator timed in ticks
// depends on mctp_pkg, mctp_ctrl, mctp_dp (which holds mctp_div)
//
// channel   dir  signals                    contents
// s_        in   tvalid tready tdata tuser  tuser: action; tdata: channel, freq, duty, shift
// m_        out  tvalid tready tdata        tdata: pin_levels, error
//
// one transaction at a time: a tick passes decode, one tick state per channel slot, finish and
// idle; a start passes decode, one pass of the bit-serial divider for the period (W =
// clog2(TICKS_PER_SECOND+1) quotient bits), multiply, scale, apply and finish; a stop passes
// decode, stop and finish; a rejected or unused command passes decode and finish.
// the result waits in an output register; a new item is taken once it is loaded there.
// rst_n clears all channels to stopped and all pins low.

module multi_channel_tick_pwm #(
    parameter int NUM_CHANNELS     = 4,
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mctp_pkg::IN_DATA_W-1:0]  s_tdata,  // channel, freq_hz, duty_percent, shifted
    input  logic [mctp_pkg::IN_USER_W-1:0]  s_tuser,  // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mctp_pkg::OUT_DATA_W-1:0] m_tdata   // pin_levels, error
);

    import mctp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mctp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mctp_dp #(
        .NUM_CHANNELS     (NUM_CHANNELS),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- hdl/mctp_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on nothing; used by mctp_dp

module mctp_div #(
    parameter int DIVIDEND_W = 17,
    parameter int DIVISOR_W  = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits back in DIVISOR_W bits
            rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- hdl/mctp_ctrl.sv -----
// sequencing state machine for the pwm block
// depends on mctp_pkg; drives commands to mctp_dp and reads its status

module mctp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output mctp_pkg::cmd_t cmd,
    input  mctp_pkg::sts_t sts
);

    import mctp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.action)
                    ACT_TICK:  state_next = ST_TICK;
                    ACT_START: state_next = sts.bad_cmd ? ST_FINISH : ST_DIV_P;
                    ACT_STOP:  state_next = sts.bad_cmd ? ST_FINISH : ST_STOP;
                    default:   state_next = ST_FINISH;
                endcase
            end
            ST_DIV_P:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_FINISH;
            ST_STOP:   state_next = ST_FINISH;
            ST_TICK:
            begin
                if (sts.idx_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DECODE: cmd.div_go = (sts.action == ACT_START) && !sts.bad_cmd;
            ST_MUL:    cmd.mul = 1'b1;
            ST_SCALE:  cmd.scale = 1'b1;
            ST_APPLY:  cmd.write_start = 1'b1;
            ST_STOP:   cmd.write_stop = 1'b1;
            ST_TICK:   cmd.tick_step = 1'b1;
            ST_FINISH: cmd.load_out = sts.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

// ----- hdl/mctp_dp.sv -----
// datapath: input capture, channel registers, period/width arithmetic, output register
// depends on mctp_pkg and mctp_div; commanded by mctp_ctrl

module mctp_dp #(
    parameter int NUM_CHANNELS     = 4,
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mctp_pkg::cmd_t                   cmd,
    output mctp_pkg::sts_t                   sts,
    input  logic [mctp_pkg::IN_DATA_W-1:0]   s_tdata,  // channel, freq_hz, duty_percent, shifted
    input  logic [mctp_pkg::IN_USER_W-1:0]   s_tuser,  // action
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mctp_pkg::OUT_DATA_W-1:0]  m_tdata   // pin_levels, error
);

    import mctp_pkg::*;

    localparam int PW = $clog2(TICKS_PER_SECOND + 1);
    localparam int DW = PW + PCT_W;
    localparam int SW = DW + RECIP_W;
    localparam logic [4:0] NCH = 5'(NUM_CHANNELS);
    localparam logic [CHAN_W-1:0] LAST_IDX = CHAN_W'(NUM_SLOTS - 1);

    typedef struct packed {
        logic [PW-1:0] cd;
        logic          nir;
        logic          level;
    } fire_t;

    // pending events fire back to back, at most two per item
    function automatic fire_t fire_due(fire_t f_in, logic [PW-1:0] per, logic [PW-1:0] hi);
        fire_t f;
        f = f_in;
        for (int n = 0; n < 2; n++)
        begin
            if (f.cd == '0)
            begin
                if (f.nir)
                begin
                    f.level = 1'b1;
                    f.cd    = hi;
                    f.nir   = 1'b0;
                end
                else
                begin
                    f.level = 1'b0;
                    f.cd    = per - hi;
                    f.nir   = 1'b1;
                end
            end
        end
        return f;
    endfunction

    action_t           act_reg;
    logic [CHAN_W-1:0] idx_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [DUTY_W-1:0] duty_reg;
    logic              shift_reg;
    logic              ch_bad;

    logic [PW-1:0]        period_reg [NUM_SLOTS];
    logic [PW-1:0]        high_reg   [NUM_SLOTS];
    logic [PW-1:0]        cd_reg     [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] nir_reg;
    logic [NUM_SLOTS-1:0] run_reg;
    logic [NUM_SLOTS-1:0] levels_reg;

    logic [PW-1:0]    p_reg;
    logic [DW-1:0]    prod_reg;
    logic [PW-1:0]    h_reg;
    logic [SW-1:0]    scaled;
    logic [PCT_W-1:0] duty_sat;
    logic [PW-1:0]    div_dividend;
    logic [FREQ_W-1:0] div_divisor;
    logic [PW-1:0]    quotient;
    logic             div_done;

    logic             out_valid_reg;
    logic [LEVELS_W-1:0] out_levels_reg;
    logic             out_err_reg;
    logic             err_flag;

    fire_t start_fire;
    fire_t tick_in;
    fire_t tick_fire;

    // capture the transaction; idx walks the channels on a tick
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg   <= action_t'(s_tuser[1:0]);
            freq_reg  <= s_tdata[9:2];
            duty_reg  <= s_tdata[17:10];
            shift_reg <= s_tdata[18];
            idx_reg   <= (action_t'(s_tuser[1:0]) == ACT_TICK) ? '0 : s_tdata[1:0];
        end
        else if (cmd.tick_step)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign ch_bad   = {3'b000, idx_reg} >= NCH;
    assign err_flag = ((act_reg == ACT_START) && ((freq_reg == '0) || ch_bad)) ||
                      ((act_reg == ACT_STOP) && ch_bad);

    assign sts.action   = act_reg;
    assign sts.bad_cmd  = err_flag;
    assign sts.div_done = div_done;
    assign sts.idx_last = idx_reg == LAST_IDX;
    assign sts.out_free = !out_valid_reg || m_tready;

    // arithmetic: period, then duty * period, then that over 100
    assign duty_sat     = (duty_reg > DUTY_W'(FULL_DUTY)) ? PCT_W'(FULL_DUTY)
                                                          : duty_reg[PCT_W-1:0];
    assign div_dividend = PW'(TICKS_PER_SECOND);
    assign div_divisor  = freq_reg;

    mctp_div #(
        .DIVIDEND_W (PW),
        .DIVISOR_W  (FREQ_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    // division by 100 through the reciprocal
    assign scaled = SW'(prod_reg) * SW'(PCT_RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            p_reg    <= quotient;
            prod_reg <= DW'(duty_sat) * DW'(quotient);
        end
        // width never exceeds the period
        if (cmd.scale)
        begin
            h_reg <= scaled[RECIP_SHIFT +: PW];
        end
    end

    always_comb
    begin
        start_fire.cd    = shift_reg ? ((p_reg >> 1) - (h_reg >> 1)) : '0;
        start_fire.nir   = 1'b0;
        start_fire.level = 1'b0;
        start_fire       = fire_due(start_fire, p_reg, h_reg);
    end

    always_comb
    begin
        tick_in.cd    = (cd_reg[idx_reg] != '0) ? cd_reg[idx_reg] - 1'b1 : cd_reg[idx_reg];
        tick_in.nir   = nir_reg[idx_reg];
        tick_in.level = levels_reg[idx_reg];
        tick_fire     = fire_due(tick_in, period_reg[idx_reg], high_reg[idx_reg]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                period_reg[i] <= '0;
                high_reg[i]   <= '0;
                cd_reg[i]     <= '0;
            end
            nir_reg    <= '0;
            run_reg    <= '0;
            levels_reg <= '0;
        end
        else if (cmd.write_start)
        begin
            period_reg[idx_reg] <= p_reg;
            high_reg[idx_reg]   <= h_reg;
            cd_reg[idx_reg]     <= start_fire.cd;
            nir_reg[idx_reg]    <= start_fire.nir;
            run_reg[idx_reg]    <= 1'b1;
            levels_reg[idx_reg] <= start_fire.level;
        end
        else if (cmd.write_stop)
        begin
            cd_reg[idx_reg]     <= '0;
            nir_reg[idx_reg]    <= 1'b0;
            run_reg[idx_reg]    <= 1'b0;
            levels_reg[idx_reg] <= 1'b0;
        end
        else if (cmd.tick_step && run_reg[idx_reg])
        begin
            cd_reg[idx_reg]     <= tick_fire.cd;
            nir_reg[idx_reg]    <= tick_fire.nir;
            levels_reg[idx_reg] <= tick_fire.level;
        end
    end

    // result register, free again once the transaction is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_levels_reg <= levels_reg[LEVELS_W-1:0];
            out_err_reg    <= err_flag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_err_reg, out_levels_reg};

endmodule
